### rtl/obt_pkg.sv
package obt_pkg;

   localparam int ID_W   = 32;
   localparam int PX_W   = 32;
   localparam int QTY_W  = 32;
   localparam int OP_W   = 2;
   localparam int STK_W  = 2;
   localparam int STAT_W = 2;
   localparam int SIZE_W = 4;

   localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
   localparam logic [OP_W-1:0] OP_EXEC   = 2'd1;
   localparam logic [OP_W-1:0] OP_CANCEL = 2'd2;

   localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [STK_W-1:0] stock;
      logic [ID_W-1:0]  order_ref;
      logic [PX_W-1:0]  price;
      logic [QTY_W-1:0] quantity;
      logic [PX_W-1:0]  prior_best;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic              better_price;
      logic              removed;
      logic [SIZE_W-1:0] book_size;
      logic [QTY_W-1:0]  remaining;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]  id;
      logic [PX_W-1:0]  price;
      logic [QTY_W-1:0] qty;
   } entry_type;

   typedef struct packed {
      logic search_en;
      logic add_en;
      logic remove_en;
      logic update_en;
   } cell_ctl_type;

endpackage

### rtl/order_book_table.sv
// channel  direction  ports                          payload
// req      in         req_valid, req_stall, req_data  obt_pkg::req_type
// rsp      out        rsp_valid, rsp_stall, rsp_data  obt_pkg::rsp_type
//
// each beat has a search cycle where every cell of the addressed book compares
// its id, then an apply cycle where the first-hit chain runs along the row and
// cells load, update or take their neighbour's entry.
// the next beat is taken in the apply cycle, while the last one is applied.
// reset clears the book counts and the handshake state; entries need no clear.
// a stalled result holds the apply cycle until the result register is free.
module order_book_table #(
   parameter int BOOK_DEPTH = 8,
   parameter int NUM_BOOKS  = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  obt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output obt_pkg::rsp_type rsp_data
);
   import obt_pkg::*;

   localparam int CNT_W = $clog2(BOOK_DEPTH+1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BOOK_DEPTH);
   localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_APPLY} state_type;

   state_type    state_ff;
   req_type      req_ff;
   rsp_type      rsp_ff, rsp_in;
   logic         rsp_valid_ff;
   logic [CNT_W-1:0] count_ff [NUM_BOOKS];
   logic [CNT_W-1:0] count_in;

   logic [NUM_BOOKS-1:0] sel;
   logic                 book_ok;
   logic [CNT_W-1:0]     count_sel;
   logic                 hit_sel;
   logic [QTY_W-1:0]     held_sel;
   logic                 apply_go, accept;
   logic                 do_add, do_remove, do_update;

   cell_ctl_type     ctl   [NUM_BOOKS];
   entry_type        ent_w [NUM_BOOKS][BOOK_DEPTH];
   logic             hit_w [NUM_BOOKS][BOOK_DEPTH+1];
   logic [QTY_W-1:0] fq_w  [NUM_BOOKS][BOOK_DEPTH];
   logic [QTY_W-1:0] held  [NUM_BOOKS];

   entry_type new_entry;
   assign new_entry = '{id: req_ff.order_ref, price: req_ff.price, qty: req_ff.quantity};

   assign apply_go  = (state_ff == S_APPLY) && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = !((state_ff == S_IDLE) || apply_go);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int b = 0; b < NUM_BOOKS; b++) begin
         sel[b] = (32'(req_ff.stock) == b);
      end
      book_ok = |sel;
   end

   genvar gb, gk;
   generate
      for (gb = 0; gb < NUM_BOOKS; gb++) begin : g_book
         assign hit_w[gb][0] = 1'b0;
         for (gk = 0; gk < BOOK_DEPTH; gk++) begin : g_cell
            entry_type nxt;
            if (gk == BOOK_DEPTH-1) begin : g_tail
               assign nxt = ent_w[gb][gk];
            end else begin : g_mid
               assign nxt = ent_w[gb][gk+1];
            end
            obt_cell #(.BOOK_DEPTH(BOOK_DEPTH), .IDX(gk)) u_cell (
               .clock      (clock),
               .ctl        (ctl[gb]),
               .count      (count_ff[gb]),
               .search_ref (req_ff.order_ref),
               .new_entry  (new_entry),
               .new_qty    (rsp_in.remaining),
               .next_entry (nxt),
               .hit_in     (hit_w[gb][gk]),
               .hit_out    (hit_w[gb][gk+1]),
               .first_qty  (fq_w[gb][gk]),
               .entry_out  (ent_w[gb][gk])
            );
         end
      end
   endgenerate

   // first-hit quantity per book, then pick the addressed book
   always_comb begin
      count_sel = '0;
      hit_sel   = 1'b0;
      held_sel  = '0;
      for (int b = 0; b < NUM_BOOKS; b++) begin
         held[b] = '0;
         for (int k = 0; k < BOOK_DEPTH; k++) begin
            held[b] = held[b] | fq_w[b][k];
         end
         if (sel[b]) begin
            count_sel = count_ff[b];
            hit_sel   = hit_w[b][BOOK_DEPTH];
            held_sel  = held[b];
         end
      end
   end

   always_comb begin
      rsp_in    = '0;
      count_in  = count_sel;
      do_add    = 1'b0;
      do_remove = 1'b0;
      do_update = 1'b0;
      if (book_ok) begin
         case (req_ff.opcode)
            OP_ADD: begin
               rsp_in.better_price = (req_ff.price > req_ff.prior_best);
               if (count_sel < DEPTH_C) begin
                  do_add   = 1'b1;
                  count_in = count_sel + ONE_C;
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end
            OP_EXEC, OP_CANCEL: begin
               if (!hit_sel) begin
                  rsp_in.status = ST_NOT_FOUND;
               end else if ((req_ff.opcode == OP_CANCEL) ||
                            (req_ff.quantity >= held_sel)) begin
                  do_remove      = 1'b1;
                  rsp_in.removed = 1'b1;
                  count_in       = count_sel - ONE_C;
               end else begin
                  do_update        = 1'b1;
                  rsp_in.remaining = held_sel - req_ff.quantity;
               end
            end
            default: begin
            end
         endcase
         rsp_in.book_size = SIZE_W'(count_in);
      end
   end

   always_comb begin
      for (int b = 0; b < NUM_BOOKS; b++) begin
         ctl[b].search_en = (state_ff == S_SEARCH) && sel[b];
         ctl[b].add_en    = apply_go && sel[b] && do_add;
         ctl[b].remove_en = apply_go && sel[b] && do_remove;
         ctl[b].update_en = apply_go && sel[b] && do_update;
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BOOKS; b++) begin
         if (reset) begin
            count_ff[b] <= '0;
         end else if (apply_go && sel[b]) begin
            count_ff[b] <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (accept) state_ff <= S_SEARCH;
            end
            S_SEARCH: begin
               state_ff <= S_APPLY;
            end
            S_APPLY: begin
               if (apply_go) state_ff <= accept ? S_SEARCH : S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
         if (apply_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (accept) req_ff <= req_data;
      if (apply_go) rsp_ff <= rsp_in;
   end

endmodule

### rtl/obt_cell.sv
module obt_cell #(
   parameter int BOOK_DEPTH = 8,
   parameter int IDX        = 0
) (
   input  logic                                  clock,
   input  obt_pkg::cell_ctl_type                 ctl,
   input  logic [$clog2(BOOK_DEPTH+1)-1:0]       count,
   input  logic [obt_pkg::ID_W-1:0]              search_ref,
   input  obt_pkg::entry_type                    new_entry,
   input  logic [obt_pkg::QTY_W-1:0]             new_qty,
   input  obt_pkg::entry_type                    next_entry,
   input  logic                                  hit_in,
   output logic                                  hit_out,
   output logic [obt_pkg::QTY_W-1:0]             first_qty,
   output obt_pkg::entry_type                    entry_out
);
   import obt_pkg::*;

   localparam int CNT_W = $clog2(BOOK_DEPTH+1);
   localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

   entry_type entry_ff, entry_in;
   logic      match_ff, match_in;
   logic      first;

   always_comb begin
      first     = match_ff & ~hit_in;
      hit_out   = hit_in | match_ff;
      first_qty = first ? entry_ff.qty : '0;
      entry_out = entry_ff;

      match_in = match_ff;
      if (ctl.search_en) begin
         match_in = (entry_ff.id == search_ref) && (MY_IDX < count);
      end

      entry_in = entry_ff;
      if (ctl.add_en && (count == MY_IDX)) begin
         entry_in = new_entry;
      end
      // at or past the removed slot: take the neighbour's entry
      if (ctl.remove_en && hit_out) begin
         entry_in = next_entry;
      end
      if (ctl.update_en && first) begin
         entry_in.qty = new_qty;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
   end

endmodule
